// File: hw/rtl/xcsd_pkg.sv
package xcsd_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned TAG_W    = 24;
  localparam int unsigned NUM_TAGS = 4;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned LEN_W    = 8;

  // Longest payload accepted before the sentence is dropped
  localparam logic [LEN_W-1:0] MAX_LEN = 8'd128;

  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

  // Offsets from ASCII code to nibble value
  localparam logic [CHAR_W-1:0] OFS_LOWER = 8'd87;
  localparam logic [CHAR_W-1:0] OFS_UPPER = 8'd55;
  localparam logic [CHAR_W-1:0] OFS_DIGIT = 8'd48;

  localparam logic [1:0] REG_TAG_ZERO  = 2'd0;
  localparam logic [1:0] REG_TAG_ONE   = 2'd1;
  localparam logic [1:0] REG_TAG_TWO   = 2'd2;
  localparam logic [1:0] REG_TAG_THREE = 2'd3;

  localparam logic [TAG_W-1:0] TAG_ZERO_RST  = 24'h434841;
  localparam logic [TAG_W-1:0] TAG_ONE_RST   = 24'h434F4F;
  localparam logic [TAG_W-1:0] TAG_TWO_RST   = 24'h444554;
  localparam logic [TAG_W-1:0] TAG_THREE_RST = 24'h484954;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_REC  = 3'd1,
    PH_HI   = 3'd2,
    PH_LO   = 3'd3,
    PH_LF   = 3'd4
  } phase_t;

  typedef enum logic [STAT_W-1:0] {
    ST_IDLE     = 3'd0,
    ST_GOOD     = 3'd1,
    ST_CKFAIL   = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_PARSED   = 3'd4,
    ST_OVERFLOW = 3'd5,
    ST_REJECT   = 3'd6
  } status_t;

  typedef logic [NUM_TAGS-1:0][TAG_W-1:0] tags_t;

  typedef struct packed {
    status_t           status;
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  payload_length;
  } result_t;

  // Bit 4 set when the character is a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_nibble(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] diff;
    begin
      diff = 8'd0;
      hex_nibble = 5'd0;
      if (c inside {[8'h61:8'h66]}) begin
        diff = c - OFS_LOWER;
        hex_nibble = {1'b1, diff[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
        diff = c - OFS_UPPER;
        hex_nibble = {1'b1, diff[3:0]};
      end else if (c inside {[8'h30:8'h39]}) begin
        diff = c - OFS_DIGIT;
        hex_nibble = {1'b1, diff[3:0]};
      end
    end
  endfunction

endpackage

// File: hw/rtl/xor_checked_sentence_deframer_core.sv
// Sentence deframer for '$payload*HH<LF>' lines with an XOR checksum. Feed one
// received character per input item; every item yields exactly one result item
// carrying a status code, the matched tag index and the payload length so far.
// The block takes one item per cycle as long as the output side keeps taking
// results: a character passes an input register and the parse logic and lands
// in the output register. The four message tags are written through the cfg
// port; the user must write them only while the block is idle, which the block
// itself does not enforce. They reset to "CHA", "COO", "DET" and "HIT".
module xor_checked_sentence_deframer_core import xcsd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input characters
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,    // [7:0] char_in
  // result items
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,   // [2:0] status, [4:3] kind,
                                         // [12:5] payload_length, [15:13] zero
  // tag registers
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [TAG_W-1:0]  cfg_wdata
);

  tags_t             tags_r;
  logic              in_valid_r;
  logic [CHAR_W-1:0] in_char_r;
  logic              out_valid_r;
  result_t           out_res_r;
  result_t           res;
  logic              advance;
  logic              step;

  // Tag registers: the user must write them only while no sentence is in flight; not enforced here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tags_r[0] <= TAG_ZERO_RST;
      tags_r[1] <= TAG_ONE_RST;
      tags_r[2] <= TAG_TWO_RST;
      tags_r[3] <= TAG_THREE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TAG_ZERO:  tags_r[0] <= cfg_wdata;
        REG_TAG_ONE:   tags_r[1] <= cfg_wdata;
        REG_TAG_TWO:   tags_r[2] <= cfg_wdata;
        REG_TAG_THREE: tags_r[3] <= cfg_wdata;
        default:       tags_r    <= tags_r;
      endcase
    end
  end

  // The output register frees up when it is empty or being taken this cycle
  assign advance   = !out_valid_r || out_tready;
  // Parse the held character whenever its result has a place to go
  assign step      = in_valid_r && advance;
  // Take a new character when the input register is empty or moves on
  assign in_tready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
    end
  end

  // Parse state and per-character decisions
  xcsd_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .char_in (in_char_r),
    .tags    (tags_r),
    .res     (res)
  );

  // Output register: load on a parse step, drop once the item is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.payload_length, out_res_r.kind,
                       out_res_r.status};

endmodule

// File: hw/rtl/xcsd_engine.sv
module xcsd_engine import xcsd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [CHAR_W-1:0] char_in,
  input  tags_t             tags,
  output result_t           res
);

  phase_t             phase_r, phase_nxt;
  logic [CHAR_W-1:0]  xor_r, xor_nxt;
  logic [CHAR_W-1:0]  sum_r, sum_nxt;
  logic [LEN_W-1:0]   count_r, count_nxt;
  logic [TAG_W-1:0]   tag_r, tag_nxt;
  logic [4:0]         hex;
  logic [CHAR_W-1:0]  sum_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      xor_r   <= '0;
      sum_r   <= '0;
      count_r <= '0;
      tag_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      tag_r   <= tag_nxt;
    end
  end

  assign hex    = hex_nibble(char_in);
  assign sum_lo = {sum_r[7:4], hex[3:0]};

  always_comb begin
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    tag_nxt   = tag_r;
    res.status = ST_IDLE;
    res.kind   = '0;
    case (phase_r)
      PH_REC: begin
        res.status = ST_GOOD;
        if (char_in == CH_STAR) begin
          phase_nxt = PH_HI;
        end else if (char_in != CH_NUL) begin
          if (count_r >= MAX_LEN) begin
            res.status = ST_OVERFLOW;
            phase_nxt  = PH_WAIT;
          end else begin
            // first three payload bytes build the tag, first byte highest
            case (count_r)
              8'd0:    tag_nxt = tag_r | {char_in, 16'h0000};
              8'd1:    tag_nxt = tag_r | {8'h00, char_in, 8'h00};
              8'd2:    tag_nxt = tag_r | {16'h0000, char_in};
              default: tag_nxt = tag_r;
            endcase
            xor_nxt   = xor_r ^ char_in;
            count_nxt = count_r + 8'd1;
          end
        end
      end
      PH_HI: begin
        if (hex[4]) begin
          sum_nxt    = {hex[3:0], 4'h0};
          phase_nxt  = PH_LO;
          res.status = ST_GOOD;
        end else begin
          res.status = ST_REJECT;
        end
      end
      PH_LO: begin
        if (hex[4]) begin
          sum_nxt = sum_lo;
          if (sum_lo == xor_r) begin
            phase_nxt  = PH_LF;
            res.status = ST_GOOD;
          end else begin
            phase_nxt  = PH_WAIT;
            res.status = ST_CKFAIL;
          end
        end else begin
          res.status = ST_REJECT;
        end
      end
      PH_LF: begin
        if (char_in == CH_LF) begin
          phase_nxt  = PH_WAIT;
          res.status = ST_PARSED;
          if (tag_r == tags[0])      res.kind = 2'd0;
          else if (tag_r == tags[1]) res.kind = 2'd1;
          else if (tag_r == tags[2]) res.kind = 2'd2;
          else if (tag_r == tags[3]) res.kind = 2'd3;
          else                       res.status = ST_UNKNOWN;
        end else begin
          res.status = ST_REJECT;
        end
      end
      default: begin
        phase_nxt = PH_WAIT;
        if (char_in == CH_DOLLAR) begin
          count_nxt  = '0;
          xor_nxt    = '0;
          tag_nxt    = '0;
          phase_nxt  = PH_REC;
          res.status = ST_GOOD;
        end
      end
    endcase
    res.payload_length = count_nxt;
  end

endmodule

// File: verif/tb_xor_checked_sentence_deframer_core.sv
`timescale 1ns / 100ps

module tb_xor_checked_sentence_deframer_core;
  import xcsd_pkg::*;

  // Ends the run if the block hangs. The slowest correct run is far below this.
  localparam int CYCLE_LIMIT = 600000;
  // Length of the forced receiver hold-off that backs the block up.
  localparam int LONG_HOLD   = 150;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;     // [7:0] char_in
  logic                out_tvalid;
  logic                out_tready;
  logic [15:0]         out_tdata;    // [2:0] status, [4:3] kind, [12:5] payload_length
  logic                cfg_we;
  logic [1:0]          cfg_addr;
  logic [TAG_W-1:0]    cfg_wdata;

  // Predicts one result item per accepted character and holds the predictions
  // until the block delivers them.
  class deframe_scoreboard;
    logic [TAG_W-1:0] tags [NUM_TAGS];
    phase_t           ph;
    logic [7:0]       xor_acc;
    logic [7:0]       sum_rx;
    logic [7:0]       byte_cnt;
    logic [TAG_W-1:0] tag_acc;
    result_t          awaited_results[$];
    int               errors;

    function new();
      tags[0]  = TAG_ZERO_RST;
      tags[1]  = TAG_ONE_RST;
      tags[2]  = TAG_TWO_RST;
      tags[3]  = TAG_THREE_RST;
      ph       = PH_WAIT;
      xor_acc  = '0;
      sum_rx   = '0;
      byte_cnt = '0;
      tag_acc  = '0;
      errors   = 0;
    endfunction

    // Nibble value of a hex digit in either case, -1 for anything else
    static function int hex_val(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return -1;
    endfunction

    function void set_tag(logic [1:0] idx, logic [TAG_W-1:0] value);
      tags[idx] = value;
    endfunction

    function void note_char(logic [7:0] c);
      result_t r;
      int      nib;
      bit      found;
      r.status = ST_IDLE;
      r.kind   = '0;
      case (ph)
        PH_REC: begin
          r.status = ST_GOOD;
          if (c == CH_STAR) begin
            ph = PH_HI;
          end else if (c != CH_NUL) begin
            if (byte_cnt >= MAX_LEN) begin
              r.status = ST_OVERFLOW;
              ph       = PH_WAIT;
            end else begin
              if (byte_cnt < 3) tag_acc |= TAG_W'(c) << (8 * (2 - byte_cnt));
              xor_acc ^= c;
              byte_cnt++;
            end
          end
        end
        PH_HI: begin
          nib = hex_val(c);
          if (nib >= 0) begin
            sum_rx   = {nib[3:0], 4'h0};
            ph       = PH_LO;
            r.status = ST_GOOD;
          end else begin
            r.status = ST_REJECT;
          end
        end
        PH_LO: begin
          nib = hex_val(c);
          if (nib >= 0) begin
            sum_rx[3:0] = nib[3:0];
            if (sum_rx == xor_acc) begin
              ph       = PH_LF;
              r.status = ST_GOOD;
            end else begin
              ph       = PH_WAIT;
              r.status = ST_CKFAIL;
            end
          end else begin
            r.status = ST_REJECT;
          end
        end
        PH_LF: begin
          if (c == CH_LF) begin
            ph    = PH_WAIT;
            found = 1'b0;
            for (int i = 0; i < NUM_TAGS; i++) begin
              if (!found && tag_acc == tags[i]) begin
                found  = 1'b1;
                r.kind = KIND_W'(i);
              end
            end
            r.status = found ? ST_PARSED : ST_UNKNOWN;
          end else begin
            r.status = ST_REJECT;
          end
        end
        default: begin
          ph = PH_WAIT;
          if (c == CH_DOLLAR) begin
            byte_cnt = '0;
            xor_acc  = '0;
            tag_acc  = '0;
            ph       = PH_REC;
            r.status = ST_GOOD;
          end
        end
      endcase
      r.payload_length = byte_cnt;
      awaited_results.push_back(r);
    endfunction

    function void check_result(logic [15:0] d);
      result_t e;
      if (awaited_results.size() == 0) begin
        $error("result item %h arrived with none expected", d);
        errors++;
        return;
      end
      e = awaited_results.pop_front();
      if (d[2:0] !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, d[2:0]);
        errors++;
      end
      if (d[4:3] !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, d[4:3]);
        errors++;
      end
      if (d[12:5] !== e.payload_length) begin
        $error("payload_length: expected %0d, got %0d", e.payload_length, d[12:5]);
        errors++;
      end
    endfunction
  endclass

  deframe_scoreboard sb = new();

  logic [7:0] line_q[$];   // characters of the line being built
  bit         no_idle = 1'b0;
  bit         hold_req = 1'b0;
  int         cycles = 0;

  xor_checked_sentence_deframer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Kill the run on a hang.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Check every result item on the edge where it is taken.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Idle length for either side: mostly none or short, now and then long.
  // Return zero while a no-idle stretch is running.
  function automatic int pick_idle();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 10) return "0" + nib;
    if ($urandom_range(0, 1)) return 8'("a" + nib - 10);
    return 8'("A" + nib - 10);
  endfunction

  function automatic logic [7:0] bad_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (deframe_scoreboard::hex_val(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] non_lf_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
    return c;
  endfunction

  // Any payload byte that neither ends the payload nor gets skipped
  function automatic logic [7:0] payload_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_STAR);
    return c;
  endfunction

  function automatic logic [TAG_W-1:0] letters3();
    return {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
            8'($urandom_range(65, 90))};
  endfunction

  // Mostly a configured tag so that sentences classify, else something unknown.
  function automatic logic [TAG_W-1:0] pick_tag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return sb.tags[$urandom_range(0, NUM_TAGS - 1)];
    if (r < 85) return letters3();
    return TAG_W'($urandom_range(0, 32'hFFFFFF));
  endfunction

  // Append '$', the tag bytes up to the first zero byte, extra payload bytes,
  // '*', two hex digits and a line feed. With noisy set, sprinkle NULs into
  // the payload and rejected characters ahead of the digits and line feed.
  function automatic void add_sentence(logic [TAG_W-1:0] tag, int extra, bit bad_ck,
                                       bit noisy);
    logic [7:0] ck;
    logic [7:0] b;
    ck = '0;
    line_q.push_back(CH_DOLLAR);
    for (int i = 2; i >= 0; i--) begin
      b = tag[8*i +: 8];
      if (b == CH_NUL) break;
      line_q.push_back(b);
      ck ^= b;
    end
    repeat (extra) begin
      if (noisy && $urandom_range(0, 4) == 0) line_q.push_back(CH_NUL);
      b = payload_char();
      line_q.push_back(b);
      ck ^= b;
    end
    line_q.push_back(CH_STAR);
    if (bad_ck) ck ^= 8'($urandom_range(1, 255));
    if (noisy && $urandom_range(0, 2) == 0) line_q.push_back(bad_hex_char());
    line_q.push_back(hex_char(ck[7:4]));
    if (noisy && $urandom_range(0, 2) == 0) line_q.push_back(bad_hex_char());
    line_q.push_back(hex_char(ck[3:0]));
    if (noisy && $urandom_range(0, 2) == 0) line_q.push_back(non_lf_char());
    line_q.push_back(CH_LF);
  endfunction

  // Offer one character, idling first if the gap says so; keep tvalid high
  // across back-to-back items.
  task automatic send_char(logic [7:0] c);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    sb.note_char(c);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_char(line_q[i]);
    line_q.delete();
  endtask

  // Drop tvalid and wait until every outstanding result has been taken, then idle on.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.awaited_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_tag(logic [1:0] idx, logic [TAG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_tag(idx, value);
    @(posedge clk);
  endtask

  // Random traffic: mostly well-formed sentences with random content, mixed with
  // bad checksums, cut-off sentences, short tags and stray noise.
  task automatic run_random(int budget);
    int sent;
    int r;
    int cut;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) no_idle = !no_idle;
      if (r < 55) begin
        add_sentence(pick_tag(), $urandom_range(0, 8), 1'b0, $urandom_range(0, 2) == 0);
      end else if (r < 60) begin
        add_sentence(pick_tag(), $urandom_range(9, 40), 1'b0, 1'b1);
      end else if (r < 70) begin
        add_sentence(pick_tag(), $urandom_range(0, 8), 1'b1, 1'($urandom_range(0, 1)));
      end else if (r < 78) begin
        // Cut the tail off so the next sentence lands in a mid-sentence state.
        add_sentence(pick_tag(), $urandom_range(0, 6), 1'($urandom_range(0, 1)), 1'b0);
        cut = $urandom_range(1, line_q.size() - 1);
        repeat (cut) void'(line_q.pop_back());
      end else if (r < 88) begin
        // Keep only the first zero, one or two tag bytes.
        cut = $urandom_range(0, 2);
        add_sentence(pick_tag() & ~(24'hFFFFFF >> (8 * cut)), 0, 1'b0,
                     1'($urandom_range(0, 1)));
      end else begin
        repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(0, 255)));
        send_line();
        continue;
      end
      sent += line_q.size();
      send_line();
    end
    no_idle = 1'b0;
  endtask

  // Receiver: random stalls and runs of ready; on request, one long hold-off
  // counted here so the block backs up and stalls its input.
  initial begin
    int stall;
    int held;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        held = 0;
        while (held < LONG_HOLD) begin
          @(posedge clk);
          held++;
        end
      end else begin
        stall = pick_idle();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_TAG_ZERO;
    cfg_wdata <= '0;
    rst_n     <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n     <= 1'b1;

    // Directed: idle bytes at both ends of the range; a HIT sentence with a
    // skipped NUL, a rejected digit and a rejected character before the line
    // feed; a '$' as the only payload byte (short tag, unknown); a lowercase
    // checksum with a leading zero that fails, followed by a stray line feed.
    line_q = {8'h00, 8'hFF,
              CH_DOLLAR, "H", "I", "T", CH_NUL, CH_STAR, "5", "G", "5", "z", CH_LF,
              CH_DOLLAR, CH_DOLLAR, CH_STAR, "2", "4", CH_LF,
              CH_DOLLAR, CH_STAR, "0", "a", CH_LF};
    send_line();

    // Reset tags; open with a payload that runs past the length limit.
    add_sentence(letters3(), MAX_LEN - 3 + $urandom_range(1, 4), 1'b0, 1'b0);
    send_line();
    run_random(150);
    drain();

    // Fresh letter tags; back the block up with a long receiver hold.
    write_tag(REG_TAG_ZERO, letters3());
    write_tag(REG_TAG_ONE, letters3());
    write_tag(REG_TAG_TWO, letters3());
    write_tag(REG_TAG_THREE, letters3());
    hold_req = 1'b1;
    run_random(160);
    drain();

    // Extremes: an all-zero tag matched by an empty payload, an all-ones tag,
    // a one-byte tag, and a duplicate where the lower index must win.
    write_tag(REG_TAG_ZERO, 24'h000000);
    write_tag(REG_TAG_ONE, 24'hFFFFFF);
    write_tag(REG_TAG_TWO, 24'h410000);
    write_tag(REG_TAG_THREE, 24'hFFFFFF);
    add_sentence(letters3(), MAX_LEN - 3, 1'b0, 1'b0);
    send_line();
    run_random(160);
    drain();

    // Arbitrary 24-bit tags.
    write_tag(REG_TAG_ZERO, TAG_W'($urandom_range(0, 32'hFFFFFF)));
    write_tag(REG_TAG_ONE, TAG_W'($urandom_range(0, 32'hFFFFFF)));
    write_tag(REG_TAG_TWO, TAG_W'($urandom_range(0, 32'hFFFFFF)));
    write_tag(REG_TAG_THREE, TAG_W'($urandom_range(0, 32'hFFFFFF)));
    hold_req = 1'b1;
    run_random(160);
    drain();

    // Give late or unrequested result items time to show, then flag any that never arrived.
    repeat (10) @(posedge clk);
    if (sb.awaited_results.size() != 0) begin
      $error("%0d result items never arrived", sb.awaited_results.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
